/* hw/rtl/fragment_reassembly_deframer_unit_defines.svh */
// Assertion helpers for the RTL files that carry checks.
`ifndef FRAGMENT_REASSEMBLY_DEFRAMER_UNIT_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is high.
`define FRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* hw/rtl/frd_pkg.sv */
package frd_pkg;

   // Fixed header layout of a media packet, big-endian.
   localparam int HeaderBytes     = 36;
   localparam int HdrAddrWidth    = $clog2(HeaderBytes);
   localparam int TrackIdOffset   = 0;
   localparam int PtsOffset       = 4;
   localparam int DtsOffset       = 12;
   localparam int DurationOffset  = 20;
   localparam int MediaInfoOffset = 28;
   localparam int DataSizeOffset  = 32;

   localparam int CfgLenWidth     = 20;
   localparam int OutLenWidth     = 20;

   // Payload kinds.
   localparam logic [2:0] KindRequest  = 3'd0;
   localparam logic [2:0] KindResponse = 3'd1;
   localparam logic [2:0] KindRequired = 3'd2;
   localparam logic [2:0] KindMedia    = 3'd3;
   localparam logic [1:0] StreamMedia  = 2'd3;

   // Result status codes.
   localparam logic [3:0] StatusNone       = 4'd0;
   localparam logic [3:0] StatusOk         = 4'd1;
   localparam logic [3:0] StatusInterleave = 4'd2;
   localparam logic [3:0] StatusMsgLong    = 4'd3;
   localparam logic [3:0] StatusEmpty      = 4'd4;
   localparam logic [3:0] StatusMediaLong  = 4'd5;
   localparam logic [3:0] StatusShortHdr   = 4'd6;
   localparam logic [3:0] StatusSizeErr    = 4'd7;
   localparam logic [3:0] StatusDropped    = 4'd8;

   // Register indexes on the configuration port.
   localparam logic [1:0] RegMaxMessageLen = 2'd0;
   localparam logic [1:0] RegMaxMediaLen   = 2'd1;
   localparam logic [1:0] RegMessagesOnly  = 2'd2;
   localparam int         CsrAddrWidth     = 4;

   typedef struct packed {
      logic [CfgLenWidth-1:0] max_message_len;
      logic [CfgLenWidth-1:0] max_media_len;
      logic                   messages_only;
   } cfg_type;

   typedef struct packed {
      logic [2:0] payload_kind;
      logic       marker;
      logic       has_byte;
      logic [7:0] data_byte;
      logic       fragment_end;
   } req_type;

   typedef struct packed {
      logic [1:0]             stream_kind;
      logic [7:0]             out_byte;
      logic                   out_byte_valid;
      logic                   done_res;
      logic [3:0]             status;
      logic [31:0]            track_ref;
      logic [63:0]            pts;
      logic [63:0]            dts;
      logic [63:0]            duration;
      logic [31:0]            media_info;
      logic [OutLenWidth-1:0] payload_length;
      logic [31:0]            dropped_media_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] track_ref;
      logic [63:0] pts;
      logic [63:0] dts;
      logic [63:0] duration;
      logic [31:0] media_info;
      logic [31:0] body_size;
   } hdr_fields_type;

endpackage

/* hw/rtl/frd_if.sv */
interface frd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] payload_kind;
   logic       marker;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       fragment_end;

   modport source (output valid, output payload_kind, output marker, output has_byte,
                   output data_byte, output fragment_end, input ready);
   modport sink   (input valid, input payload_kind, input marker, input has_byte,
                   input data_byte, input fragment_end, output ready);
endinterface

interface frd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        stream_kind;
   logic [7:0]                        out_byte;
   logic                              out_byte_valid;
   logic                              done_res;
   logic [3:0]                        status;
   logic [31:0]                       track_ref;
   logic [63:0]                       pts;
   logic [63:0]                       dts;
   logic [63:0]                       duration;
   logic [31:0]                       media_info;
   logic [frd_pkg::OutLenWidth-1:0]   payload_length;
   logic [31:0]                       dropped_media_count;

   modport source (output valid, output stream_kind, output out_byte, output out_byte_valid,
                   output done_res, output status, output track_ref, output pts, output dts,
                   output duration, output media_info, output payload_length,
                   output dropped_media_count, input ready);
   modport sink   (input valid, input stream_kind, input out_byte, input out_byte_valid,
                   input done_res, input status, input track_ref, input pts, input dts,
                   input duration, input media_info, input payload_length,
                   input dropped_media_count, output ready);
endinterface

/* hw/rtl/fragment_reassembly_deframer_unit.sv */
// Fragment reassembly deframer.
// The req_chan channel carries one fragment byte per beat, tagged with its
// payload kind, the end-of-message marker and an end-of-fragment flag. Every
// accepted beat produces exactly one beat on rsp_chan: a forwarded byte, a
// completion or abort status, or an empty status beat for bytes that are held
// back (media header) or discarded. Control messages are passed cut-through;
// media packets have their 36-byte header parsed and reported on the closing
// beat. The APB port sets the two length limits and the messages-only mode;
// the user must write registers only while the block is idle; not enforced.
// Throughput is one beat per cycle while rsp_chan does not stall. An accepted
// beat is registered in the input stage and then in the result register, which
// offers it on rsp_chan. The state update and the header store write happen in
// the same cycle as the result register load.
// When the receiver stalls, the result register holds and the input stage
// keeps one more beat; req_chan.ready then drops until the result is taken.
// Synchronous reset clears all control state and sets the limits to their
// maxima; the header bytes are not cleared and no clearing pass is needed.
`include "fragment_reassembly_deframer_unit_defines.svh"

module fragment_reassembly_deframer_unit #(
   parameter int LENGTH_WIDTH = 21
) (
   input  logic                             clock,
   input  logic                             reset,
   frd_req_if.sink                          req_chan,
   frd_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [frd_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;

   frd_pkg::cfg_type        cfg;
   frd_pkg::hdr_fields_type hdr;

   // Input stage and result register.
   frd_pkg::req_type stg_ff, stg_in;
   logic             stg_valid_ff, stg_valid_in;
   frd_pkg::rsp_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   logic             req_accept, advance;

   // Reassembly state.
   logic [LENGTH_WIDTH-1:0] msg_len_ff, msg_len_in;
   logic [1:0]              msg_type_ff, msg_type_in;
   logic                    msg_open_ff, msg_open_in;
   logic [LENGTH_WIDTH-1:0] media_len_ff, media_len_in;
   logic                    in_frag_ff, in_frag_in;
   logic                    frag_rej_ff, frag_rej_in;
   logic [2:0]              frag_kind_ff, frag_kind_in;
   logic                    overflowed_ff, overflowed_in;
   logic [31:0]             drop_cnt_ff, drop_cnt_in;

   // Header store write request from the step logic.
   logic                             hdr_we;
   logic [frd_pkg::HdrAddrWidth-1:0] hdr_addr;

   // Terms used by the checks at the end.
   logic drop_beat;
   logic media_quiet;

   frd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   frd_hdr_store u_hdr_store (
      .clock      (clock),
      .write_en   (hdr_we && advance),
      .write_addr (hdr_addr),
      .write_data (stg_ff.data_byte),
      .fields     (hdr)
   );

   // Handshake: the input stage moves on whenever the result register is free
   // or is being emptied in this cycle.
   assign advance          = stg_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !stg_valid_ff || advance;
   assign req_accept       = req_chan.valid && req_chan.ready;

   always_comb begin
      stg_in.payload_kind = req_chan.payload_kind;
      stg_in.marker       = req_chan.marker;
      stg_in.has_byte     = req_chan.has_byte;
      stg_in.data_byte    = req_chan.data_byte;
      stg_in.fragment_end = req_chan.fragment_end;
      if (req_accept) begin
         stg_valid_in = 1'b1;
      end else if (advance) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Step logic for the beat in the input stage.
   always_comb begin
      logic        rej;
      logic [2:0]  fk;
      logic [31:0] pos32;
      logic [31:0] media_pay32;
      logic [31:0] msg_len32;

      msg_len_in    = msg_len_ff;
      msg_type_in   = msg_type_ff;
      msg_open_in   = msg_open_ff;
      media_len_in  = media_len_ff;
      overflowed_in = overflowed_ff;
      drop_cnt_in   = drop_cnt_ff;
      out_in        = '0;
      hdr_we        = 1'b0;
      rej           = frag_rej_ff;
      fk            = frag_kind_ff;
      pos32         = 32'(media_len_ff);
      hdr_addr      = pos32[frd_pkg::HdrAddrWidth-1:0];

      // First beat of a fragment: sample the kind and decide whether the
      // fragment is taken at all.
      if (!in_frag_ff) begin
         rej = 1'b0;
         fk  = stg_ff.payload_kind;
         if (fk <= frd_pkg::KindRequired) begin
            if (msg_open_ff && (msg_type_ff != fk[1:0])) begin
               // A fragment of another kind aborts the open message and is
               // itself discarded.
               out_in.stream_kind = msg_type_ff;
               out_in.done_res    = 1'b1;
               out_in.status      = frd_pkg::StatusInterleave;
               msg_len_in         = '0;
               msg_type_in        = '0;
               msg_open_in        = 1'b0;
               rej                = 1'b1;
            end else begin
               msg_open_in = 1'b1;
               msg_type_in = fk[1:0];
            end
         end else if (fk == frd_pkg::KindMedia) begin
            if (cfg.messages_only) begin
               // Dropped media fragment; the counter sticks at all ones.
               if (!overflowed_ff) begin
                  drop_cnt_in = drop_cnt_ff + 32'd1;
               end
               if (drop_cnt_in == '1) begin
                  overflowed_in = 1'b1;
               end
               out_in.stream_kind = frd_pkg::StreamMedia;
               out_in.status      = frd_pkg::StatusDropped;
               rej                = 1'b1;
            end
         end else begin
            rej = 1'b1;
         end
      end

      // Data byte of an accepted fragment.
      if (!rej && stg_ff.has_byte) begin
         if (fk <= frd_pkg::KindRequired) begin
            if (msg_len_in != LenMax) begin
               msg_len_in = msg_len_in + LENGTH_WIDTH'(1);
            end
            out_in.stream_kind = fk[1:0];
            if (32'(msg_len_in) > 32'(cfg.max_message_len)) begin
               out_in.done_res = 1'b1;
               out_in.status   = frd_pkg::StatusMsgLong;
               msg_len_in      = '0;
               msg_type_in     = '0;
               msg_open_in     = 1'b0;
               rej             = 1'b1;
            end else begin
               out_in.out_byte       = stg_ff.data_byte;
               out_in.out_byte_valid = 1'b1;
            end
         end else begin
            if (media_len_ff != LenMax) begin
               media_len_in = media_len_ff + LENGTH_WIDTH'(1);
            end
            out_in.stream_kind = frd_pkg::StreamMedia;
            if (32'(media_len_in) > 32'(cfg.max_media_len)) begin
               out_in.done_res = 1'b1;
               out_in.status   = frd_pkg::StatusMediaLong;
               media_len_in    = '0;
               rej             = 1'b1;
            end else if (pos32 < 32'(frd_pkg::HeaderBytes)) begin
               hdr_we = 1'b1;
            end else begin
               out_in.out_byte       = stg_ff.data_byte;
               out_in.out_byte_valid = 1'b1;
            end
         end
      end

      msg_len32   = 32'(msg_len_in);
      media_pay32 = 32'(media_len_in) - 32'(frd_pkg::HeaderBytes);

      // Closing beat of the last fragment of a message or media packet.
      if (stg_ff.fragment_end && !rej && stg_ff.marker) begin
         out_in.done_res = 1'b1;
         if (fk <= frd_pkg::KindRequired) begin
            out_in.stream_kind = fk[1:0];
            if (msg_len_in == '0) begin
               out_in.status = frd_pkg::StatusEmpty;
            end else begin
               out_in.status         = frd_pkg::StatusOk;
               out_in.payload_length = msg_len32[frd_pkg::OutLenWidth-1:0];
            end
            msg_len_in  = '0;
            msg_type_in = '0;
            msg_open_in = 1'b0;
         end else begin
            out_in.stream_kind = frd_pkg::StreamMedia;
            if (32'(media_len_in) < 32'(frd_pkg::HeaderBytes)) begin
               out_in.status = frd_pkg::StatusShortHdr;
            end else if (hdr.body_size != media_pay32) begin
               out_in.status = frd_pkg::StatusSizeErr;
            end else begin
               out_in.status         = frd_pkg::StatusOk;
               out_in.track_ref      = hdr.track_ref;
               out_in.pts            = hdr.pts;
               out_in.dts            = hdr.dts;
               out_in.duration       = hdr.duration;
               out_in.media_info     = hdr.media_info;
               out_in.payload_length = media_pay32[frd_pkg::OutLenWidth-1:0];
            end
            media_len_in = '0;
         end
      end

      in_frag_in   = !stg_ff.fragment_end;
      frag_rej_in  = stg_ff.fragment_end ? 1'b0 : rej;
      frag_kind_in = fk;
      out_in.dropped_media_count = drop_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stg_ff <= stg_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         msg_len_ff    <= '0;
         msg_type_ff   <= '0;
         msg_open_ff   <= 1'b0;
         media_len_ff  <= '0;
         in_frag_ff    <= 1'b0;
         frag_rej_ff   <= 1'b0;
         frag_kind_ff  <= '0;
         overflowed_ff <= 1'b0;
         drop_cnt_ff   <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            msg_len_ff    <= msg_len_in;
            msg_type_ff   <= msg_type_in;
            msg_open_ff   <= msg_open_in;
            media_len_ff  <= media_len_in;
            in_frag_ff    <= in_frag_in;
            frag_rej_ff   <= frag_rej_in;
            frag_kind_ff  <= frag_kind_in;
            overflowed_ff <= overflowed_in;
            drop_cnt_ff   <= drop_cnt_in;
         end
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.stream_kind         = out_ff.stream_kind;
   assign rsp_chan.out_byte            = out_ff.out_byte;
   assign rsp_chan.out_byte_valid      = out_ff.out_byte_valid;
   assign rsp_chan.done_res            = out_ff.done_res;
   assign rsp_chan.status              = out_ff.status;
   assign rsp_chan.track_ref           = out_ff.track_ref;
   assign rsp_chan.pts                 = out_ff.pts;
   assign rsp_chan.dts                 = out_ff.dts;
   assign rsp_chan.duration            = out_ff.duration;
   assign rsp_chan.media_info          = out_ff.media_info;
   assign rsp_chan.payload_length      = out_ff.payload_length;
   assign rsp_chan.dropped_media_count = out_ff.dropped_media_count;

   assign drop_beat   = out_valid_ff && (out_ff.status == frd_pkg::StatusDropped);
   assign media_quiet = !out_ff.done_res && (out_ff.stream_kind == frd_pkg::StreamMedia);

   // A beat leaving the input stage always lands in the result register.
   `FRD_ASSERT_NEXT(a_advance_loads_result, clock, reset, advance, out_valid_ff)
   // The sticky saturation flag only stands with a full counter.
   `FRD_ASSERT_NOW(a_overflow_full, clock, reset, overflowed_ff, drop_cnt_ff == '1)
   // The drop counter never goes backward outside reset.
   `FRD_ASSERT_NEXT(a_drop_monotonic, clock, reset, 1'b1, drop_cnt_ff >= $past(drop_cnt_ff))
   // A dropped-media beat is a media beat that closes nothing.
   `FRD_ASSERT_NOW(a_drop_no_done, clock, reset, drop_beat, media_quiet)

endmodule

/* hw/rtl/frd_csr.sv */
module frd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [frd_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output frd_pkg::cfg_type                 cfg
);

   frd_pkg::cfg_type cfg_ff, cfg_in;
   logic             write_en;
   logic [1:0]       reg_index;

   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            frd_pkg::RegMaxMessageLen: cfg_in.max_message_len = pwdata[frd_pkg::CfgLenWidth-1:0];
            frd_pkg::RegMaxMediaLen:   cfg_in.max_media_len   = pwdata[frd_pkg::CfgLenWidth-1:0];
            frd_pkg::RegMessagesOnly:  cfg_in.messages_only   = pwdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         frd_pkg::RegMaxMessageLen: prdata = 32'(cfg_ff.max_message_len);
         frd_pkg::RegMaxMediaLen:   prdata = 32'(cfg_ff.max_media_len);
         frd_pkg::RegMessagesOnly:  prdata = 32'(cfg_ff.messages_only);
         default:                   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_message_len <= '1;
         cfg_ff.max_media_len   <= '1;
         cfg_ff.messages_only   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/frd_hdr_store.sv */
module frd_hdr_store (
   input  logic                             clock,
   input  logic                             write_en,
   input  logic [frd_pkg::HdrAddrWidth-1:0] write_addr,
   input  logic [7:0]                       write_data,
   output frd_pkg::hdr_fields_type          fields
);

   logic [7:0] hdr_ff [frd_pkg::HeaderBytes];
   logic [7:0] view   [frd_pkg::HeaderBytes];

   // The byte written on the closing beat is already visible to the field view.
   always_comb begin
      for (int i = 0; i < frd_pkg::HeaderBytes; i++) begin
         if (write_en && (32'(write_addr) == i)) begin
            view[i] = write_data;
         end else begin
            view[i] = hdr_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         fields.track_ref[31-8*i -: 8]  = view[frd_pkg::TrackIdOffset + i];
         fields.media_info[31-8*i -: 8] = view[frd_pkg::MediaInfoOffset + i];
         fields.body_size[31-8*i -: 8]  = view[frd_pkg::DataSizeOffset + i];
      end
      for (int i = 0; i < 8; i++) begin
         fields.pts[63-8*i -: 8]      = view[frd_pkg::PtsOffset + i];
         fields.dts[63-8*i -: 8]      = view[frd_pkg::DtsOffset + i];
         fields.duration[63-8*i -: 8] = view[frd_pkg::DurationOffset + i];
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         hdr_ff[write_addr] <= write_data;
      end
   end

endmodule
